// File: sv/congestion_window_and_rto_controller_unit_macros.svh
`ifndef CONGESTION_WINDOW_AND_RTO_CONTROLLER_UNIT_MACROS_SVH
`define CONGESTION_WINDOW_AND_RTO_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication
`define CWRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cwrc check failed");

// next-cycle implication
`define CWRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cwrc check failed");

`endif

// File: sv/cwrc_pkg.sv
package cwrc_pkg;

    localparam int W_KIND  = 2;
    localparam int W_TIME  = 32;
    localparam int W_BYTES = 24;
    localparam int W_SEQ   = 32;
    localparam int W_PAY   = 16;
    localparam int W_PROD  = W_PAY + W_BYTES;
    localparam int W_CIDX  = 3;
    localparam int W_CDATA = 32;
    localparam int W_SDATA = 144;
    localparam int W_MDATA = 88;
    localparam int DIV_STEPS = W_BYTES;
    localparam int W_CNT   = $clog2(DIV_STEPS);
    localparam int W_EXT   = W_TIME + 3;

    localparam logic [W_TIME-1:0]  RST_MIN_RTO     = 32'd200000;
    localparam logic [W_TIME-1:0]  RST_MAX_RTO     = 32'd60000000;
    localparam logic [W_TIME-1:0]  RST_INIT_RTO    = 32'd1000000;
    localparam logic [W_PAY-1:0]   RST_MAX_PAYLOAD = 16'd1200;
    localparam logic [W_BYTES-1:0] RST_MIN_CWND    = 24'd2400;
    localparam logic [W_BYTES-1:0] RST_MAX_CWND    = 24'd4194304;
    localparam logic [W_BYTES-1:0] RST_INIT_CWND   = 24'd12000;
    localparam logic [W_BYTES-1:0] RST_INIT_SSTH   = 24'hFFFFFF;

    typedef enum logic [W_KIND-1:0] {
        K_RTT  = 2'd0,
        K_ACK  = 2'd1,
        K_LOSS = 2'd2,
        K_TMO  = 2'd3
    } t_kind;

    typedef enum logic [W_CIDX-1:0] {
        CFG_MIN_RTO      = 3'd0,
        CFG_MAX_RTO      = 3'd1,
        CFG_INIT_RTO     = 3'd2,
        CFG_MAX_PAYLOAD  = 3'd3,
        CFG_MIN_CWND     = 3'd4,
        CFG_MAX_CWND     = 3'd5,
        CFG_INIT_CWND    = 3'd6,
        CFG_INIT_SSTH    = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL,
        S_DIVINIT,
        S_DIV,
        S_WIN,
        S_RTO,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic sample;
        logic ack_close;
        logic ss_grow;
        logic mul;
        logic div_init;
        logic div_step;
        logic ai_grow;
        logic rto_est;
        logic loss;
        logic tmo;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  acked_zero;
        logic  slow_start;
        logic  have_sample;
        logic  div_sat;
        logic  div_last;
        logic  out_busy;
    } t_sts;

endpackage

// File: sv/cwrc_ctrl.sv
module cwrc_ctrl
    import cwrc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.kind)
                    K_RTT: n_state = S_RTO;
                    K_ACK: begin
                        if (i_sts.acked_zero) begin
                            n_state = S_DONE;
                        end else if (i_sts.slow_start) begin
                            n_state = i_sts.have_sample ? S_RTO : S_DONE;
                        end else begin
                            n_state = S_MUL;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_MUL:     n_state = S_DIVINIT;
            S_DIVINIT: n_state = i_sts.div_sat ? S_WIN : S_DIV;
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_WIN;
                end
            end
            S_WIN:  n_state = i_sts.have_sample ? S_RTO : S_DONE;
            S_RTO:  n_state = S_DONE;
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DISPATCH: begin
                o_cmd.sample    = (i_sts.kind == K_RTT);
                o_cmd.ack_close = (i_sts.kind == K_ACK);
                o_cmd.ss_grow   = (i_sts.kind == K_ACK) && !i_sts.acked_zero
                                  && i_sts.slow_start;
                o_cmd.loss      = (i_sts.kind == K_LOSS);
                o_cmd.tmo       = (i_sts.kind == K_TMO);
            end
            S_MUL:     o_cmd.mul      = 1'b1;
            S_DIVINIT: o_cmd.div_init = 1'b1;
            S_DIV:     o_cmd.div_step = 1'b1;
            S_WIN:     o_cmd.ai_grow  = 1'b1;
            S_RTO:     o_cmd.rto_est  = 1'b1;
            S_DONE:    o_cmd.out_load = !i_sts.out_busy;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: sv/cwrc_dp.sv
module cwrc_dp
    import cwrc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [W_CIDX-1:0]  i_cfg_addr,
    input  logic [W_CDATA-1:0] i_cfg_data,
    input  logic [W_KIND-1:0]  i_kind,
    input  logic [W_SDATA-1:0] i_data,
    input  t_cmd               i_cmd,
    input  logic               i_out_ready,
    output t_sts               o_sts,
    output logic               o_out_valid,
    output logic [W_MDATA-1:0] o_out_data
);

    logic [W_TIME-1:0]  r_min_rto, r_max_rto, r_init_rto;
    logic [W_PAY-1:0]   r_max_payload;
    logic [W_BYTES-1:0] r_min_cwnd, r_max_cwnd, r_init_cwnd, r_init_ssth;

    t_kind              r_kind;
    logic [W_TIME-1:0]  r_rtt;
    logic [W_BYTES-1:0] r_acked;
    logic [W_SEQ-1:0]   r_ack_seq;
    logic [W_SEQ-1:0]   r_highest;
    logic [W_BYTES-1:0] r_flight;

    logic [W_BYTES-1:0] r_cwnd, r_ssth;
    logic [W_TIME-1:0]  r_srtt, r_var, r_rto;
    logic               r_have, r_rec, r_reduced;
    logic [W_SEQ-1:0]   r_rp;

    logic [W_PROD-1:0]  r_prod;
    logic [W_BYTES-1:0] r_rem, r_quo;
    logic [W_CNT-1:0]   r_cnt;
    logic               r_sat;

    logic               r_out_valid;
    logic [W_MDATA-1:0] r_out_data;

    logic [W_BYTES-1:0] div_v;
    logic [W_BYTES-W_PAY-1:0] hi_pad;
    logic [W_BYTES:0]   trial;
    logic [W_BYTES:0]   trial_sub;
    logic [W_BYTES-1:0] ss_cap, ss_add, ai_inc;
    logic [W_BYTES:0]   ss_sum, ai_sum;
    logic [W_BYTES-1:0] ss_new, ai_new;
    logic [W_TIME-1:0]  err;
    logic [W_TIME+1:0]  var_sum;
    logic [W_EXT-1:0]   srtt_sum, est_sum, dbl_rto;
    logic [W_BYTES-1:0] loss_half, tmo_half;
    logic [W_SEQ-1:0]   seq_gap;

    function automatic logic [W_TIME-1:0] f_clamp(input logic [W_EXT-1:0] v,
                                                  input logic [W_TIME-1:0] lo,
                                                  input logic [W_TIME-1:0] hi);
        logic [W_TIME-1:0] res;
        if (v < {3'b000, lo}) begin
            res = lo;
        end else if (v > {3'b000, hi}) begin
            res = hi;
        end else begin
            res = v[W_TIME-1:0];
        end
        return res;
    endfunction

    always_comb begin
        div_v     = (r_cwnd == '0) ? {{(W_BYTES-1){1'b0}}, 1'b1} : r_cwnd;
        hi_pad    = '0;
        trial     = {r_rem, r_quo[W_BYTES-1]};
        trial_sub = trial - {1'b0, div_v};

        ss_cap = {{(W_BYTES-W_PAY-1){1'b0}}, r_max_payload, 1'b0};
        ss_add = (r_acked < ss_cap) ? r_acked : ss_cap;
        ss_sum = {1'b0, r_cwnd} + {1'b0, ss_add};
        ss_new = (ss_sum > {1'b0, r_max_cwnd}) ? r_max_cwnd : ss_sum[W_BYTES-1:0];

        ai_inc = (r_quo == '0) ? {{(W_BYTES-1){1'b0}}, 1'b1} : r_quo;
        ai_sum = {1'b0, r_cwnd} + {1'b0, ai_inc};
        ai_new = (r_sat || ai_sum > {1'b0, r_max_cwnd}) ? r_max_cwnd
                                                        : ai_sum[W_BYTES-1:0];

        err      = (r_srtt > r_rtt) ? (r_srtt - r_rtt) : (r_rtt - r_srtt);
        var_sum  = {1'b0, r_var, 1'b0} + {2'b00, r_var} + {2'b00, err};
        srtt_sum = {r_srtt, 3'b000} - {3'b000, r_srtt} + {3'b000, r_rtt};
        est_sum  = {3'b000, r_srtt} + {1'b0, r_var, 2'b00};
        dbl_rto  = {2'b00, r_rto, 1'b0};

        loss_half = {1'b0, r_cwnd[W_BYTES-1:1]};
        tmo_half  = {1'b0, r_flight[W_BYTES-1:1]};
        seq_gap   = r_ack_seq - r_rp;
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rto     <= RST_MIN_RTO;
            r_max_rto     <= RST_MAX_RTO;
            r_init_rto    <= RST_INIT_RTO;
            r_max_payload <= RST_MAX_PAYLOAD;
            r_min_cwnd    <= RST_MIN_CWND;
            r_max_cwnd    <= RST_MAX_CWND;
            r_init_cwnd   <= RST_INIT_CWND;
            r_init_ssth   <= RST_INIT_SSTH;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_MIN_RTO:     r_min_rto     <= i_cfg_data;
                CFG_MAX_RTO:     r_max_rto     <= i_cfg_data;
                CFG_INIT_RTO:    r_init_rto    <= i_cfg_data;
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[W_PAY-1:0];
                CFG_MIN_CWND:    r_min_cwnd    <= i_cfg_data[W_BYTES-1:0];
                CFG_MAX_CWND:    r_max_cwnd    <= i_cfg_data[W_BYTES-1:0];
                CFG_INIT_CWND:   r_init_cwnd   <= i_cfg_data[W_BYTES-1:0];
                CFG_INIT_SSTH:   r_init_ssth   <= i_cfg_data[W_BYTES-1:0];
                default: begin
                end
            endcase
        end
    end

    // item word, multiply, divider and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= t_kind'(i_kind);
            r_rtt     <= i_data[31:0];
            r_acked   <= i_data[55:32];
            r_ack_seq <= i_data[87:56];
            r_highest <= i_data[119:88];
            r_flight  <= i_data[143:120];
        end
        if (i_cmd.mul) begin
            r_prod <= W_PROD'(r_max_payload * r_acked);
        end
        if (i_cmd.div_init) begin
            r_sat <= o_sts.div_sat;
            r_rem <= {hi_pad, r_prod[W_PROD-1:W_BYTES]};
            r_quo <= r_prod[W_BYTES-1:0];
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            if (!trial_sub[W_BYTES]) begin
                r_rem <= trial_sub[W_BYTES-1:0];
                r_quo <= {r_quo[W_BYTES-2:0], 1'b1};
            end else begin
                r_rem <= trial[W_BYTES-1:0];
                r_quo <= {r_quo[W_BYTES-2:0], 1'b0};
            end
            r_cnt <= r_cnt + W_CNT'(1);
        end
        if (i_cmd.out_load) begin
            r_out_data <= {6'b0, r_reduced, r_rec, r_rto, r_ssth, r_cwnd};
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cwnd      <= RST_INIT_CWND;
            r_ssth      <= RST_INIT_SSTH;
            r_srtt      <= '0;
            r_var       <= '0;
            r_rto       <= RST_INIT_RTO;
            r_have      <= 1'b0;
            r_rec       <= 1'b0;
            r_rp        <= '0;
            r_reduced   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_reduced <= 1'b0;
            end
            if (i_cmd.sample) begin
                r_have <= 1'b1;
                if (!r_have) begin
                    r_srtt <= r_rtt;
                    r_var  <= {1'b0, r_rtt[W_TIME-1:1]};
                end else begin
                    r_srtt <= srtt_sum[W_EXT-1:3];
                    r_var  <= var_sum[W_TIME+1:2];
                end
            end
            if (i_cmd.ack_close && r_rec && !seq_gap[W_SEQ-1]) begin
                r_rec <= 1'b0;
            end
            if (i_cmd.ss_grow) begin
                r_cwnd <= ss_new;
            end
            if (i_cmd.ai_grow) begin
                r_cwnd <= ai_new;
            end
            if (i_cmd.rto_est) begin
                r_rto <= f_clamp(est_sum, r_min_rto, r_max_rto);
            end
            if (i_cmd.loss && !r_rec) begin
                r_rec     <= 1'b1;
                r_rp      <= r_highest;
                r_ssth    <= (loss_half > r_min_cwnd) ? loss_half : r_min_cwnd;
                r_cwnd    <= (loss_half > r_min_cwnd) ? loss_half : r_min_cwnd;
                r_reduced <= 1'b1;
            end
            if (i_cmd.tmo) begin
                r_rec     <= 1'b1;
                r_rp      <= r_highest;
                r_ssth    <= (tmo_half > r_min_cwnd) ? tmo_half : r_min_cwnd;
                r_cwnd    <= {{(W_BYTES-W_PAY){1'b0}}, r_max_payload};
                r_rto     <= f_clamp(dbl_rto, r_min_rto, r_max_rto);
                r_reduced <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.kind        = r_kind;
    assign o_sts.acked_zero  = (r_acked == '0);
    assign o_sts.slow_start  = (r_cwnd < r_ssth);
    assign o_sts.have_sample = r_have;
    assign o_sts.div_sat     = ({hi_pad, r_prod[W_PROD-1:W_BYTES]} >= div_v);
    assign o_sts.div_last    = (r_cnt == W_CNT'(DIV_STEPS - 1));
    assign o_sts.out_busy    = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: sv/congestion_window_and_rto_controller_unit.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: kind; tdata: event fields
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: window, threshold, rto, flags
// cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_addr index, i_cfg_data value
//
// An ack in congestion avoidance runs a 16x24 multiply and, unless the
// quotient saturates, a 24-step restoring divide by the window, one
// quotient bit per cycle, to size the window increase.
// Reset is synchronous, active low; configuration is always ready.
// A result held on a stalled m_axis holds the controller in its final step.
module congestion_window_and_rto_controller_unit
    import cwrc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [143:120] flight_bytes, [119:88] highest_seq, [87:56] ack_seq,
    // [55:32] acked, [31:0] rtt_sample
    input  logic [W_SDATA-1:0] s_axis_tdata,
    // [1:0] kind
    input  logic [W_KIND-1:0]  s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [87:82] zero, [81] reduced, [80] recovering, [79:48] rto,
    // [47:24] ssthresh, [23:0] cwnd
    output logic [W_MDATA-1:0] m_axis_tdata,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [W_CIDX-1:0]  i_cfg_addr,
    input  logic [W_CDATA-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    cwrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    cwrc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_kind      (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_cmd       (cmd),
        .i_out_ready (m_axis_tready),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// File: sv/cwrc_chk.sv
`include "congestion_window_and_rto_controller_unit_macros.svh"

module cwrc_chk
    import cwrc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [W_MDATA-1:0] m_axis_tdata
);

    `CWRC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `CWRC_ASSERT_NXT(a_one_word_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `CWRC_ASSERT_IMP(a_reduce_opens_recovery, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[81], m_axis_tdata[80])

endmodule

bind congestion_window_and_rto_controller_unit cwrc_chk u_cwrc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
